// ----- src/lrn_pkg.sv -----
// ----------------------------------------------------------------------------
// lrn_pkg
// Shared types, register codes and interpolation tables of the cross-channel
// local response normalization block.
// ----------------------------------------------------------------------------
package lrn_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] CFG_ALPHA_GAIN  = 2'd1;
    localparam logic [1:0] CFG_BETA_EXP    = 2'd2;
    localparam logic [1:0] CFG_BIAS_K      = 2'd3;

    // Segment end points of log2(1+f) in Q.16.
    localparam logic [16:0] LOG_T [17] = '{
        17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
        17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
        17'd56229, 17'd59434, 17'd62534, 17'd65536};

    // Segment end points of 2^f in Q.16.
    localparam logic [17:0] EXP_T [17] = '{
        18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
        18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072};

    // Scale parameters seen by the normalization unit.
    typedef struct packed {
        logic [31:0] alpha_gain;
        logic [15:0] beta_exponent;
        logic [31:0] bias_k;
    } lrn_cfg_t;

    // Status of the normalization unit.
    typedef struct packed {
        logic busy;
        logic done;
    } lrn_norm_status_t;

    typedef enum logic [2:0] {
        T_IDLE, T_PUSH, T_START, T_WAIT, T_EMIT, T_CLEAR
    } lrn_top_state_t;

    typedef enum logic [3:0] {
        N_IDLE, N_MUL_HI, N_MUL_LO, N_DIV, N_SCALE, N_LOGNORM, N_LOG_MUL,
        N_POW_MUL, N_EXP_MUL, N_OUT_MUL, N_ROUND, N_DONE
    } lrn_norm_state_t;

endpackage

// ----- src/lrn_norm_unit.sv -----
// ----------------------------------------------------------------------------
// lrn_norm_unit
// Sequenced normalization of one activation: scale term, bit-serial divide,
// log2, power and exp2 through one shared 16x36 multiplier.
// ----------------------------------------------------------------------------
module lrn_norm_unit
    import lrn_pkg::*;
#(
    parameter int HALF_W = 3
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [15:0]       x_in,
    input  logic [35:0]              sum_in,
    input  logic [HALF_W-1:0]        half_in,
    input  lrn_cfg_t                 cfg,
    output lrn_norm_status_t         status,
    output logic signed [15:0]       result
);

    localparam int DW = HALF_W + 1;

    lrn_norm_state_t state_reg, state_next;

    logic [15:0]  mag_reg;
    logic         neg_reg;
    logic [35:0]  sum_reg;
    logic [DW-1:0] div_reg;
    logic [51:0]  acc_reg;
    logic [DW-1:0] rem_reg;
    logic [5:0]   cnt_reg;
    logic [55:0]  s_reg;
    logic [5:0]   e_reg;
    logic signed [23:0] log_reg;
    logic signed [39:0] z_reg;
    logic [17:0]  pw_reg;
    logic signed [11:0] n_reg;
    logic [35:0]  m_reg;
    logic signed [15:0] result_reg;

    // Shared multiplier with its operand select.
    logic [15:0] mul_a;
    logic [35:0] mul_b;
    logic [51:0] mul_p;

    logic [3:0]  seg;
    logic [15:0] wgt;
    logic [23:0] log_mag;

    always_comb begin
        seg = 4'd0;
        wgt = 16'd0;
        if (state_reg == N_LOG_MUL) begin
            seg = s_reg[54:51];
            wgt = s_reg[50:35];
        end else begin
            seg = z_reg[27:24];
            wgt = z_reg[23:8];
        end
        log_mag = log_reg[23] ? 24'(-log_reg) : 24'(log_reg);
        mul_a = 16'd0;
        mul_b = 36'd0;
        case (state_reg)
            N_MUL_HI: begin
                mul_a = cfg.alpha_gain[31:16];
                mul_b = sum_reg;
            end
            N_MUL_LO: begin
                mul_a = cfg.alpha_gain[15:0];
                mul_b = sum_reg;
            end
            N_LOG_MUL: begin
                mul_a = 16'(LOG_T[5'(seg) + 5'd1] - LOG_T[5'(seg)]);
                mul_b = 36'(wgt);
            end
            N_POW_MUL: begin
                mul_a = cfg.beta_exponent;
                mul_b = 36'(log_mag);
            end
            N_EXP_MUL: begin
                mul_a = 16'(EXP_T[5'(seg) + 5'd1] - EXP_T[5'(seg)]);
                mul_b = 36'(wgt);
            end
            N_OUT_MUL: begin
                mul_a = mag_reg;
                mul_b = 36'(pw_reg);
            end
            default: begin
                mul_a = 16'd0;
                mul_b = 36'd0;
            end
        endcase
        mul_p = 52'(mul_a) * 52'(mul_b);
    end

    // Divider step, scale and rounding helpers.
    logic [DW:0]   rem_trial;
    logic          rem_ge;
    logic [55:0]   scale;
    logic signed [12:0] shift_amt;
    logic [36:0]   rounded;
    logic [16:0]   limit;
    logic [16:0]   clamped;
    logic signed [23:0] e_bias;

    always_comb begin
        rem_trial = {rem_reg, acc_reg[51]};
        rem_ge    = rem_trial >= {1'b0, div_reg};
        scale     = 56'(cfg.bias_k) + 56'(acc_reg);
        shift_amt = 13'sd16 - 13'(n_reg);
        limit     = neg_reg ? 17'd32768 : 17'd32767;
        rounded   = 37'd0;
        if (shift_amt > 13'sd0 && shift_amt < 13'sd40) begin
            rounded = (37'(m_reg) + (37'd1 << (6'(shift_amt) - 6'd1))) >> 6'(shift_amt);
        end
        if (shift_amt <= 13'sd0) begin
            clamped = limit;
        end else if (rounded > 37'(limit)) begin
            clamped = limit;
        end else begin
            clamped = 17'(rounded);
        end
        e_bias = $signed({18'd0, e_reg}) - 24'sd24;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE:    if (start) state_next = (x_in == 16'sd0) ? N_DONE : N_MUL_HI;
            N_MUL_HI:  state_next = N_MUL_LO;
            N_MUL_LO:  state_next = N_DIV;
            N_DIV:     if (cnt_reg == 6'd51) state_next = N_SCALE;
            N_SCALE: begin
                if (scale != 56'd0) state_next = N_LOGNORM;
                else if (cfg.beta_exponent != 16'd0) state_next = N_DONE;
                else state_next = N_OUT_MUL;
            end
            N_LOGNORM: if (s_reg[55]) state_next = N_LOG_MUL;
            N_LOG_MUL: state_next = N_POW_MUL;
            N_POW_MUL: state_next = N_EXP_MUL;
            N_EXP_MUL: state_next = N_OUT_MUL;
            N_OUT_MUL: state_next = N_ROUND;
            N_ROUND:   state_next = N_DONE;
            N_DONE:    state_next = N_IDLE;
            default:   state_next = N_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        status.busy = state_reg != N_IDLE;
        status.done = state_reg == N_DONE;
        result      = result_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers, one step of the sequence per cycle.
    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    neg_reg    <= x_in[15];
                    mag_reg    <= x_in[15] ? 16'(-x_in) : 16'(x_in);
                    sum_reg    <= sum_in;
                    div_reg    <= {half_in, 1'b1};
                    result_reg <= 16'sd0;
                end
            end
            N_MUL_HI: acc_reg <= mul_p;
            N_MUL_LO: begin
                acc_reg <= acc_reg + 52'(mul_p[51:16]);
                rem_reg <= '0;
                cnt_reg <= 6'd0;
            end
            N_DIV: begin
                acc_reg <= {acc_reg[50:0], rem_ge};
                rem_reg <= rem_ge ? DW'(rem_trial - {1'b0, div_reg}) : rem_trial[DW-1:0];
                cnt_reg <= cnt_reg + 6'd1;
            end
            N_SCALE: begin
                s_reg      <= scale;
                e_reg      <= 6'd55;
                pw_reg     <= 18'd65536;
                n_reg      <= 12'sd0;
                result_reg <= neg_reg ? -16'sd32768 : 16'sd32767;
            end
            N_LOGNORM: begin
                if (!s_reg[55]) begin
                    s_reg <= {s_reg[54:0], 1'b0};
                    e_reg <= e_reg - 6'd1;
                end
            end
            N_LOG_MUL: begin
                log_reg <= (e_bias <<< 16) + $signed({7'd0, LOG_T[5'(seg)]})
                           + $signed({7'd0, mul_p[32:16]});
            end
            N_POW_MUL: z_reg <= log_reg[23] ? $signed(mul_p[39:0]) : -$signed(mul_p[39:0]);
            N_EXP_MUL: begin
                pw_reg <= EXP_T[5'(seg)] + mul_p[33:16];
                n_reg  <= z_reg[39:28];
            end
            N_OUT_MUL: m_reg <= mul_p[35:0];
            N_ROUND:   result_reg <= neg_reg ? 16'(-clamped) : 16'(clamped);
            default: begin
            end
        endcase
    end

endmodule

// ----- src/cross_channel_local_response_norm.sv -----
// ----------------------------------------------------------------------------
// cross_channel_local_response_norm
// Streaming cross-channel LRN over Q8.8 activations with a sliding window of
// squares and a sequenced log2/exp2 power unit.
// ----------------------------------------------------------------------------
// Activations enter one beat at a time, channels fastest, with last_channel
// on the final channel of a pixel; each result beat is delayed by half a
// window and the last channel flushes the held-back results. An input beat
// is captured in T_IDLE and enters the window in T_PUSH; each result it
// causes then passes the normalization unit, where a 52-step bit-serial
// divide by the window width 2*half+1 and a leading-one search of up to 55
// one-bit shifts dominate. A zero scale skips the log2 and exp2 steps, and a
// zero activation the whole sequence. The last beat of a pixel adds up to
// half a window of such results, each after a flush push, then a window
// clear. Configuration is taken at any time but must be written idle.
module cross_channel_local_response_norm
    import lrn_pkg::*;
#(
    parameter int MAX_WINDOW   = 15,
    parameter int MAX_CHANNELS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_in_value,
    input  logic               s_last_channel,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_value,
    output logic               m_pixel_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
    localparam int DEPTH    = HALF_MAX + 1;
    localparam int HWW      = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
    localparam int WIW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CHAN_CAP = ((MAX_CHANNELS - 1) > HALF_MAX) ? (MAX_CHANNELS - 1) : HALF_MAX;
    localparam int CW       = $clog2(CHAN_CAP + 1);

    // Configuration registers.
    logic [3:0]  window_size_reg;
    lrn_cfg_t    cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg       <= 4'd5;
            cfg_reg.alpha_gain    <= 32'd16777216;
            cfg_reg.beta_exponent <= 16'd3072;
            cfg_reg.bias_k        <= 32'd16777216;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WINDOW_SIZE: window_size_reg       <= cfg_data[3:0];
                CFG_ALPHA_GAIN:  cfg_reg.alpha_gain    <= cfg_data;
                CFG_BETA_EXP:    cfg_reg.beta_exponent <= cfg_data[15:0];
                CFG_BIAS_K:      cfg_reg.bias_k        <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    lrn_top_state_t state_reg, state_next;

    logic signed [15:0] x_reg;
    logic               last_reg;
    logic [CW-1:0]      t_reg;
    logic [CW-1:0]      count_reg;
    logic [HWW-1:0]     hw_reg;
    logic [HWW-1:0]     f_reg;
    logic               done_flag_reg;
    logic [31:0]        win_reg [MAX_WINDOW];
    logic signed [15:0] delay_reg [DEPTH];
    logic [35:0]        sum_reg;
    logic               m_valid_reg;
    logic signed [15:0] out_value_reg;
    logic               pixel_done_reg;

    // Half window from the programmed size, capped by the storage.
    logic [2:0]     h_full;
    logic [HWW-1:0] h_cap;

    always_comb begin
        h_full = (window_size_reg == 4'd0) ? 3'd0 : 3'((window_size_reg - 4'd1) >> 1);
        h_cap  = (32'(h_full) > HALF_MAX) ? HWW'(HALF_MAX) : HWW'(h_full);
    end

    // Window push and emit decisions.
    logic               flushing;
    logic signed [15:0] push_val;
    logic signed [31:0] sq;
    logic [HWW:0]       top;
    logic               emit_now;
    logic               out_free;
    logic               more_flush;
    lrn_top_state_t     adv_state;

    always_comb begin
        flushing   = f_reg != '0;
        push_val   = flushing ? 16'sd0 : x_reg;
        sq         = push_val * push_val;
        top        = {hw_reg, 1'b0};
        emit_now   = flushing ? ((CW + 1)'(t_reg) + (CW + 1)'(f_reg) >= (CW + 1)'(hw_reg))
                              : (t_reg >= CW'(hw_reg));
        out_free   = !m_valid_reg || m_ready;
        more_flush = last_reg && (f_reg < hw_reg);
        adv_state  = more_flush ? T_PUSH : (last_reg ? T_CLEAR : T_IDLE);
    end

    lrn_norm_status_t   norm_status;
    logic signed [15:0] norm_result;

    lrn_norm_unit #(
        .HALF_W (HWW)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == T_START),
        .x_in    (delay_reg[hw_reg]),
        .sum_in  (sum_reg),
        .half_in (hw_reg),
        .cfg     (cfg_reg),
        .status  (norm_status),
        .result  (norm_result)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:  if (s_valid) state_next = T_PUSH;
            T_PUSH:  state_next = emit_now ? T_START : adv_state;
            T_START: state_next = T_WAIT;
            T_WAIT:  if (norm_status.done) state_next = T_EMIT;
            T_EMIT:  if (out_free) state_next = adv_state;
            T_CLEAR: state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready      = state_reg == T_IDLE;
        m_valid      = m_valid_reg;
        m_out_value  = out_value_reg;
        m_pixel_done = pixel_done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == T_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result beat register.
    always_ff @(posedge aclk) begin
        if (state_reg == T_EMIT && out_free) begin
            out_value_reg  <= norm_result;
            pixel_done_reg <= done_flag_reg;
        end
    end

    // Channel window, delay line and pixel bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= 36'd0;
            hw_reg    <= HWW'(2);
            f_reg     <= '0;
            for (int j = 0; j < MAX_WINDOW; j++) win_reg[j] <= 32'd0;
            for (int j = 0; j < DEPTH; j++) delay_reg[j] <= 16'sd0;
        end else begin
            case (state_reg)
                T_IDLE: begin
                    if (s_valid) begin
                        x_reg    <= s_in_value;
                        last_reg <= s_last_channel;
                        t_reg    <= count_reg;
                        f_reg    <= '0;
                        if (count_reg == '0) hw_reg <= h_cap;
                        if (count_reg < CW'(CHAN_CAP)) count_reg <= count_reg + CW'(1);
                    end
                end
                T_PUSH: begin
                    sum_reg <= sum_reg + 36'(unsigned'(sq)) - 36'(win_reg[top[WIW-1:0]]);
                    win_reg[0] <= sq;
                    for (int j = 1; j < MAX_WINDOW; j++) win_reg[j] <= win_reg[j-1];
                    delay_reg[0] <= push_val;
                    for (int j = 1; j < DEPTH; j++) delay_reg[j] <= delay_reg[j-1];
                    done_flag_reg <= flushing ? (f_reg == hw_reg)
                                              : (last_reg && hw_reg == '0);
                    if (!emit_now && more_flush) f_reg <= f_reg + HWW'(1);
                end
                T_EMIT: begin
                    if (out_free && more_flush) f_reg <= f_reg + HWW'(1);
                end
                T_CLEAR: begin
                    count_reg <= '0;
                    sum_reg   <= 36'd0;
                    for (int j = 0; j < MAX_WINDOW; j++) win_reg[j] <= 32'd0;
                    for (int j = 0; j < DEPTH; j++) delay_reg[j] <= 16'sd0;
                end
                default: begin
                end
            endcase
        end
    end

    // The input side is open only while the normalization unit is free.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !norm_status.busy)
        else $error("input ready while normalization busy");

    // A started normalization keeps the unit busy on the next cycle.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_START) |=> norm_status.busy)
        else $error("normalization did not start");

    // The channel counter saturates at its cap.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CHAN_CAP)
        else $error("channel count beyond cap");

    // A waiting result beat is never overwritten.
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_value)))
        else $error("result beat overwritten");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cross-channel local response normalization
// block: a bit-exact predictor fed by every accepted input beat, a checker on
// the result channel, directed tests and constrained-by-hand random pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import lrn_pkg::*;

    localparam int HALF_MAX   = 7;
    localparam int CHAN_CAP   = 4095;
    localparam int WATCHDOG   = 200000;

    // One expected result beat.
    typedef struct {
        logic signed [15:0] value;
        logic               done;
    } lrn_beat_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_in_value = '0;
    logic               s_last_channel = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_out_value;
    logic               m_pixel_done;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    cross_channel_local_response_norm dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_in_value, .s_last_channel,
        .m_valid, .m_ready, .m_out_value, .m_pixel_done,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the block's registers and window state.
    logic [3:0]         win_reg;
    logic [31:0]        alpha_reg;
    logic [15:0]        beta_reg;
    logic [31:0]        bias_reg;
    logic [31:0]        sq_hist [HALF_MAX*2+1];
    logic signed [31:0] held_vals [HALF_MAX+1];
    logic [63:0]        sq_total;
    int                 chan_seen;
    int                 half_w;

    lrn_beat_t          expected_q [$];
    int                 fail_count = 0;
    int                 idle_cycles = 0;
    bit                 bursts_on = 1'b1;
    bit                 hold_results = 1'b0;

    function automatic logic [63:0] log2_q16(logic [63:0] s);
        int         e;
        logic [63:0] fr, i, t, l;
        e = 63;
        while (e > 0 && s[e] == 1'b0) e--;
        if (e >= 20) fr = (s >> (e - 20)) & 64'hFFFFF;
        else fr = (s << (20 - e)) & 64'hFFFFF;
        i = fr >> 16;
        t = fr & 64'hFFFF;
        l = 64'(LOG_T[i]) + (((64'(LOG_T[i+1]) - 64'(LOG_T[i])) * t) >> 16);
        return 64'((longint'(e) - 24) * 65536 + longint'(l));
    endfunction

    // Normalized output of one held activation against the current sum.
    function automatic logic signed [15:0] lrn_scale_value(logic signed [31:0] x);
        logic [63:0] p, scale, mag, lim, pw, m, r, fr, i, t, u;
        longint      z, n, s;
        bit          neg;
        p = 64'(alpha_reg >> 16) * sq_total
            + ((64'(alpha_reg & 32'hFFFF) * sq_total) >> 16);
        scale = 64'(bias_reg) + p / 64'(2 * half_w + 1);
        neg = x < 0;
        mag = neg ? 64'(-x) : 64'(x);
        lim = neg ? 64'd32768 : 64'd32767;
        if (x == 0) return '0;
        if (scale == 0) begin
            if (beta_reg != 0) return neg ? -16'sd32768 : 16'sd32767;
            pw = 65536;
            n = 0;
        end else begin
            z = -(longint'(beta_reg) * longint'(log2_q16(scale)));
            if (z >= 0) begin
                n = z >>> 28;
            end else begin
                u = 64'(-z);
                n = -longint'((u + 64'hFFFFFFF) >> 28);
            end
            fr = 64'(z - n * 268435456);
            i = fr >> 24;
            t = (fr >> 8) & 64'hFFFF;
            pw = 64'(EXP_T[i]) + (((64'(EXP_T[i+1]) - 64'(EXP_T[i])) * t) >> 16);
        end
        m = mag * pw;
        s = 16 - n;
        if (s <= 0) begin
            if (-s >= 32) r = lim;
            else r = m << (-s);
        end else if (s >= 40) begin
            r = 0;
        end else begin
            r = (m + (64'd1 << (s - 1))) >> s;
        end
        if (r > lim) r = lim;
        return neg ? 16'(-longint'(r)) : 16'(r);
    endfunction

    function automatic void clear_window();
        foreach (sq_hist[j]) sq_hist[j] = '0;
        foreach (held_vals[j]) held_vals[j] = '0;
        sq_total = '0;
        chan_seen = 0;
    endfunction

    function automatic void shift_in(logic signed [31:0] x);
        logic [31:0] sq;
        int          top;
        sq = 32'(x * x);
        top = 2 * half_w;
        sq_total = sq_total + 64'(sq) - 64'(sq_hist[top]);
        for (int j = top; j > 0; j--) sq_hist[j] = sq_hist[j-1];
        sq_hist[0] = sq;
        for (int j = half_w; j > 0; j--) held_vals[j] = held_vals[j-1];
        held_vals[0] = x;
    endfunction

    function automatic void push_result(logic signed [15:0] v, logic d);
        lrn_beat_t b;
        b.value = v;
        b.done = d;
        expected_q.push_back(b);
    endfunction

    // Works out every result beat that one accepted activation causes.
    function automatic void predict_activation(logic signed [15:0] v, logic last);
        int h, seen;
        if (chan_seen == 0) begin
            h = (win_reg == 0) ? 0 : (int'(win_reg) - 1) >> 1;
            half_w = (h > HALF_MAX) ? HALF_MAX : h;
        end
        seen = chan_seen;
        shift_in(32'(v));
        if (seen >= half_w)
            push_result(lrn_scale_value(held_vals[half_w]), last && half_w == 0);
        if (chan_seen < CHAN_CAP) chan_seen++;
        if (last) begin
            for (int f = 1; f <= half_w; f++) begin
                shift_in(0);
                if (seen + f >= half_w)
                    push_result(lrn_scale_value(held_vals[half_w]), f == half_w);
            end
            clear_window();
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Result checker and input-beat predictor, both on the rising edge.
    always @(posedge aclk) begin
        lrn_beat_t b;
        if (aresetn) begin
            if (s_valid && s_ready) predict_activation(s_in_value, s_last_channel);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat value %0d",
                                              m_out_value));
                end else begin
                    b = expected_q.pop_front();
                    if (m_out_value !== b.value)
                        report_mismatch($sformatf("out_value %0d, want %0d",
                                                  m_out_value, b.value));
                    if (m_pixel_done !== b.done)
                        report_mismatch($sformatf("pixel_done %0b, want %0b",
                                                  m_pixel_done, b.done));
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat, outside reset and result hold-off.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn || hold_results)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[cross_channel_local_response_norm] ERROR");
            $finish;
        end
    end

    // Result-side ready with random stall bursts and one forced hold-off.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // The valid drop and the next beat fall on different falling edges; the
    // block is busy on the cycle after an accept, so no offer is lost.
    task automatic send_activation(logic signed [15:0] v, logic last);
        if (bursts_on && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        s_valid <= 1'b1;
        s_in_value <= v;
        s_last_channel <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_WINDOW_SIZE: win_reg = data[3:0];
            CFG_ALPHA_GAIN:  alpha_reg = data;
            CFG_BETA_EXP:    beta_reg = data[15:0];
            CFG_BIAS_K:      bias_reg = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Waits for every expected beat, then for the last in-flight work.
    task automatic drain_results();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic set_config(logic [3:0] w, logic [31:0] a, logic [15:0] b,
                              logic [31:0] k);
        drain_results();
        write_reg(CFG_WINDOW_SIZE, 32'(w));
        write_reg(CFG_ALPHA_GAIN, a);
        write_reg(CFG_BETA_EXP, 32'(b));
        write_reg(CFG_BIAS_K, k);
    endtask

    function automatic logic signed [15:0] rand_activation();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 1023)) - 16'sd512;
            2: return 16'sd0;
            default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
        endcase
    endfunction

    task automatic send_pixel(int channels);
        for (int c = 0; c < channels; c++)
            send_activation(rand_activation(), c == channels - 1);
    endtask

    // Field extremes, zero input and short pixels with reset settings.
    task automatic test_extremes();
        send_activation(16'sh7FFF, 1'b0);
        send_activation(-16'sd32768, 1'b0);
        send_activation(16'sd0, 1'b0);
        send_activation(16'sd1, 1'b0);
        send_activation(-16'sd1, 1'b0);
        send_activation(16'sd256, 1'b1);
        send_activation(16'sh5555, 1'b1);
        send_activation(16'shAAAA, 1'b0);
        send_activation(-16'sd300, 1'b1);
    endtask

    // Zero scale, zero beta, even and zero windows, largest window.
    task automatic test_special_cases();
        set_config(4'd3, 32'd0, 16'd4096, 32'd0);
        send_activation(16'sd100, 1'b0);
        send_activation(-16'sd100, 1'b0);
        send_activation(16'sd0, 1'b1);
        set_config(4'd4, 32'd0, 16'd0, 32'd0);
        send_activation(16'sd1234, 1'b0);
        send_activation(-16'sd77, 1'b1);
        set_config(4'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_activation(16'sh7FFF, 1'b0);
        send_activation(-16'sd32768, 1'b1);
        set_config(4'd15, 32'd1, 16'd1, 32'd1);
        send_activation(16'sd500, 1'b0);
        send_activation(-16'sd9000, 1'b1);
        set_config(4'd14, 32'h0100_0000, 16'h0C00, 32'h0000_4000);
        send_pixel(17);
    endtask

    // Window change takes effect at the next pixel only.
    task automatic test_window_change();
        set_config(4'd5, 32'h0080_0000, 16'h1000, 32'h0100_0000);
        send_activation(16'sd600, 1'b0);
        send_activation(16'sd700, 1'b0);
        drain_results();
        write_reg(CFG_WINDOW_SIZE, 32'd9);
        send_activation(-16'sd800, 1'b0);
        send_activation(16'sd900, 1'b1);
        send_pixel(6);
    endtask

    // Long result hold-off while inputs keep coming, then a sender pause.
    task automatic test_backpressure();
        set_config(4'd7, 32'h0200_0000, 16'h0C00, 32'h0100_0000);
        hold_results = 1'b1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_results = 1'b0;
            end
            send_pixel(10);
        join
        drain_results();
        send_pixel(4);
    endtask

    // Random pixels over random settings; no idling in the last part.
    task automatic test_random();
        int sent;
        sent = 0;
        for (int p = 0; sent < 62; p++) begin
            if (p % 4 == 0)
                set_config(4'($urandom_range(0, 15)), $urandom, 16'($urandom),
                           ($urandom_range(0, 3) == 0) ? $urandom
                                                       : 32'($urandom_range(0, 1 << 26)));
            if (sent > 40) bursts_on = 1'b0;
            begin
                int n;
                n = $urandom_range(1, 12);
                send_pixel(n);
                sent += n;
            end
        end
    endtask

    initial begin
        win_reg = 4'd5;
        alpha_reg = 32'h0100_0000;
        beta_reg = 16'd3072;
        bias_reg = 32'h0100_0000;
        half_w = 2;
        clear_window();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_extremes();
        test_special_cases();
        test_window_change();
        test_backpressure();
        test_random();
        drain_results();

        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("[cross_channel_local_response_norm] OK");
        end else begin
            $display("[cross_channel_local_response_norm] ERROR");
        end
        $finish;
    end

endmodule
